FILE: design/ldct_pkg.sv
package ldct_pkg;

  // Operation codes carried in the op field of an input transaction.
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_SET_DELAY  = 3'd3,
    OP_SET_MARKED = 3'd4,
    OP_CAPTURE    = 3'd5
  } op_e;

  localparam int unsigned DelayBits  = 32;
  localparam int unsigned ReportBits = 16;

  typedef struct packed {
    logic [2:0]           op;
    logic [DelayBits-1:0] delay;
  } in_t;

  typedef struct packed {
    logic                  fired;
    logic [ReportBits-1:0] count_now;
    logic [ReportBits-1:0] compare_now;
    logic [DelayBits-1:0]  remaining_now;
  } out_t;

endpackage

FILE: design/ldct_split.sv
// One split step of a long delay: move the compare base and trim the time left.
module ldct_split #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic [COUNTER_BITS-1:0]         base_i,
  input  logic [ldct_pkg::DelayBits-1:0]  left_i,
  output logic [COUNTER_BITS-1:0]         base_o,
  output logic [ldct_pkg::DelayBits-1:0]  left_o
);

  localparam int unsigned WideBits = ldct_pkg::DelayBits + 2;
  localparam logic [WideBits-1:0] Period    = WideBits'(1) << COUNTER_BITS;
  localparam logic [WideBits-1:0] TwoPeriod = WideBits'(1) << (COUNTER_BITS + 1);

  logic [WideBits-1:0]               left_wide;
  logic [ldct_pkg::DelayBits-1:0]    half;

  assign left_wide = WideBits'(left_i);
  assign half      = left_i >> 1;

  always_comb begin
    if (left_wide <= Period) begin
      // Fits in one counter period: finish here.
      base_o = base_i + left_i[COUNTER_BITS-1:0];
      left_o = '0;
    end else if (left_wide <= TwoPeriod) begin
      // Two periods at most: take half now, the rest at the next match.
      base_o = base_i + half[COUNTER_BITS-1:0];
      left_o = left_i - half;
    end else begin
      // Wait one full wrap.
      base_o = base_i;
      left_o = left_i - Period[ldct_pkg::DelayBits-1:0];
    end
  end

endmodule

FILE: design/long_delay_compare_timer.sv
// Channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o  | ldct_pkg::in_t  (op, delay)
// out     | output    | out_valid_o/out_stall_i | ldct_pkg::out_t (fired, count,
//         |           |                      |   compare, remaining)
//
// Each transaction passes through the input register and then the result
// register; a new transaction is taken every cycle unless the input stalls.
// Timer state update is a single split-step pass: one per clock unless stalled.
// Reset clears the counter, compare base, time left, marker and run flag.
// The input side stalls only while an item waits in the input register and the
// result register is full and stalled.
module long_delay_compare_timer #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ldct_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ldct_pkg::out_t out_data_o
);

  localparam int unsigned DB = ldct_pkg::DelayBits;

  // Input register.
  logic           in_vld_q;
  ldct_pkg::in_t  in_q;

  // Result register.
  logic           out_vld_q;
  ldct_pkg::out_t out_q;

  // Timer state.
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic [COUNTER_BITS-1:0] base_q, base_d;
  logic [COUNTER_BITS-1:0] mark_q, mark_d;
  logic [DB-1:0]           left_q, left_d;
  logic                    run_q, run_d;
  logic                    fired;

  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [COUNTER_BITS-1:0] split_base_in, split_base_out;
  logic [DB-1:0]           split_left_in, split_left_out;

  logic accept;
  logic advance;
  ldct_pkg::op_e op;

  // Advance the input item whenever the result register can take it.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign op      = ldct_pkg::op_e'(in_q.op);
  assign cnt_inc = cnt_q + COUNTER_BITS'(1);

  // Pick what the split step works on for this op.
  always_comb begin
    split_base_in = base_q;
    split_left_in = in_q.delay;
    unique case (op)
      ldct_pkg::OP_TICK: begin
        split_left_in = left_q;
      end
      ldct_pkg::OP_START: begin
        split_base_in = '0;
      end
      ldct_pkg::OP_SET_MARKED: begin
        split_base_in = mark_q;
      end
      default: begin
      end
    endcase
  end

  ldct_split #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_split (
    .base_i(split_base_in),
    .left_i(split_left_in),
    .base_o(split_base_out),
    .left_o(split_left_out)
  );

  // Next timer state; unused op codes leave everything as it is.
  always_comb begin
    cnt_d  = cnt_q;
    base_d = base_q;
    mark_d = mark_q;
    left_d = left_q;
    run_d  = run_q;
    fired  = 1'b0;
    unique case (op)
      ldct_pkg::OP_TICK: begin
        if (run_q) begin
          cnt_d = cnt_inc;
          // A match is seen only when the counter steps onto the compare value.
          if (cnt_inc == base_q) begin
            if (left_q == '0) begin
              fired = 1'b1;
            end else begin
              base_d = split_base_out;
              left_d = split_left_out;
            end
          end
        end
      end
      ldct_pkg::OP_START: begin
        cnt_d  = '0;
        base_d = split_base_out;
        left_d = split_left_out;
        run_d  = 1'b1;
      end
      ldct_pkg::OP_STOP: begin
        run_d = 1'b0;
      end
      ldct_pkg::OP_SET_DELAY, ldct_pkg::OP_SET_MARKED: begin
        base_d = split_base_out;
        left_d = split_left_out;
      end
      ldct_pkg::OP_CAPTURE: begin
        mark_d = cnt_q;
      end
      default: begin
      end
    endcase
  end

  // Control and timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      base_q    <= '0;
      mark_q    <= '0;
      left_q    <= '0;
      run_q     <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        cnt_q     <= cnt_d;
        base_q    <= base_d;
        mark_q    <= mark_d;
        left_q    <= left_d;
        run_q     <= run_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.fired         <= fired;
      out_q.count_now     <= ldct_pkg::ReportBits'(cnt_d);
      out_q.compare_now   <= ldct_pkg::ReportBits'(base_d);
      out_q.remaining_now <= left_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/tb_long_delay_compare_timer.sv
`timescale 1ns / 1ps

module tb_long_delay_compare_timer;

  // Codes that the block must ignore.
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // One counter period and two, in ticks.
  localparam logic [31:0] PERIOD      = 32'h0001_0000;
  localparam logic [31:0] TWO_PERIODS = 32'h0002_0000;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  // Timer mirror: tracks the counter, compare base, time left and marker,
  // and holds the reports the block still owes.
  class compare_timer_board;
    logic [15:0]    count;
    logic [15:0]    base;
    logic [31:0]    time_left;
    logic [15:0]    marker;
    bit             running;
    ldct_pkg::out_t expected_reports[$];
    int             errors;

    function new();
      count     = '0;
      base      = '0;
      time_left = '0;
      marker    = '0;
      running   = 1'b0;
      errors    = 0;
    endfunction

    // Take one compare step out of the time left.
    function void split_step();
      logic [31:0] half;
      if (time_left <= PERIOD) begin
        base      = base + time_left[15:0];
        time_left = '0;
      end else if (time_left <= TWO_PERIODS) begin
        half      = time_left >> 1;
        base      = base + half[15:0];
        time_left = time_left - half;
      end else begin
        time_left = time_left - PERIOD;
      end
    endfunction

    function void note_request(ldct_pkg::in_t req);
      ldct_pkg::out_t rpt;
      rpt = '0;
      case (req.op)
        ldct_pkg::OP_TICK: begin
          if (running) begin
            count = count + 16'd1;
            if (count == base) begin
              if (time_left == '0) rpt.fired = 1'b1;
              else split_step();
            end
          end
        end
        ldct_pkg::OP_START: begin
          count     = '0;
          base      = '0;
          time_left = req.delay;
          split_step();
          running   = 1'b1;
        end
        ldct_pkg::OP_STOP: running = 1'b0;
        ldct_pkg::OP_SET_DELAY: begin
          time_left = req.delay;
          split_step();
        end
        ldct_pkg::OP_SET_MARKED: begin
          base      = marker;
          time_left = req.delay;
          split_step();
        end
        ldct_pkg::OP_CAPTURE: marker = count;
        default: ;
      endcase
      rpt.count_now     = count;
      rpt.compare_now   = base;
      rpt.remaining_now = time_left;
      expected_reports.push_back(rpt);
    endfunction

    function void check_report(ldct_pkg::out_t got);
      ldct_pkg::out_t want;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: fired=%0d count=%h compare=%h remaining=%h",
               got.fired, got.count_now, got.compare_now, got.remaining_now);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, got.fired);
        errors++;
      end
      if (got.count_now !== want.count_now) begin
        $error("count_now: expected %h, actual %h", want.count_now, got.count_now);
        errors++;
      end
      if (got.compare_now !== want.compare_now) begin
        $error("compare_now: expected %h, actual %h", want.compare_now, got.compare_now);
        errors++;
      end
      if (got.remaining_now !== want.remaining_now) begin
        $error("remaining_now: expected %h, actual %h",
               want.remaining_now, got.remaining_now);
        errors++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  ldct_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  ldct_pkg::out_t out_data_o;

  compare_timer_board board;

  int  idle_pct    = 0;   // sender idle chance per cycle, in percent
  int  stall_pct   = 0;   // receiver stall chance per cycle, in percent
  int  phase_items = 0;   // accepted transactions the block acts on
  int  cycle_count = 0;
  bit  pressure_go = 1'b0;

  // Owned by the receiver process alone.
  int  hold_left     = 0;
  bit  pressure_done = 1'b0;

  long_delay_compare_timer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_long_delay_compare_timer: FAIL");
      $finish;
    end
  end

  // Receiver: stall at random, and once hold off for a long stretch so the
  // block fills up and pushes back on the sender.
  always @(posedge clk_i) begin
    if (pressure_go && !pressure_done) begin
      hold_left     = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every report taken at this edge; values read here are the ones
  // that held before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_report(out_data_o);
  end

  // Offer one transaction, idling first at random, and hold it until taken.
  task automatic drive_request(input logic [2:0] op, input logic [31:0] delay);
    ldct_pkg::in_t req;
    req.op    = op;
    req.delay = delay;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req);
    if (op <= ldct_pkg::OP_CAPTURE) phase_items++;
  endtask

  // Advance the counter; the delay field is a don't-care on a tick.
  task automatic tick_run(input int n);
    repeat (n) drive_request(ldct_pkg::OP_TICK, $urandom());
  endtask

  // Favor the split boundaries, else any 32-bit value.
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PERIOD;
      2:       return PERIOD + 32'd1;
      3:       return TWO_PERIODS;
      4:       return TWO_PERIODS + 32'd1;
      5:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // One random sequence. Most are well formed, so the counter actually
  // reaches the compare value; the rest is noise.
  task automatic run_burst();
    int kind;
    int d;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // Short delay from start, ticked through to the fire.
      d = $urandom_range(40);
      drive_request(ldct_pkg::OP_START, d);
      repeat (d + $urandom_range(4)) begin
        if ($urandom_range(9) == 0) drive_request(ldct_pkg::OP_CAPTURE, $urandom());
        drive_request(ldct_pkg::OP_TICK, $urandom());
      end
    end else if (kind < 55) begin
      // Compare set just ahead of a captured marker.
      drive_request(ldct_pkg::OP_START, pick_delay());
      tick_run($urandom_range(20));
      drive_request(ldct_pkg::OP_CAPTURE, $urandom());
      d = $urandom_range(30);
      drive_request(ldct_pkg::OP_SET_MARKED, d);
      tick_run(d + $urandom_range(3));
    end else if (kind < 70) begin
      // Leave time over at a near match so the match takes a split step.
      drive_request(ldct_pkg::OP_START, pick_delay());
      tick_run($urandom_range(10));
      drive_request(ldct_pkg::OP_CAPTURE, $urandom());
      d = $urandom_range(1, 30);
      drive_request(ldct_pkg::OP_SET_MARKED, d);
      drive_request(ldct_pkg::OP_SET_DELAY, $urandom_range(32'h0003_0000, 32'h0002_0001));
      tick_run(d + $urandom_range(3));
    end else if (kind < 80) begin
      // Stopped timer ignores ticks; restart afterwards.
      drive_request(ldct_pkg::OP_STOP, $urandom());
      tick_run($urandom_range(5));
      drive_request(ldct_pkg::OP_SET_DELAY, pick_delay());
      drive_request(ldct_pkg::OP_START, $urandom_range(10));
      tick_run($urandom_range(12));
    end else begin
      repeat ($urandom_range(1, 8)) drive_request(3'($urandom_range(7)), pick_delay());
    end
  endtask

  initial begin
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stopped timer, unused codes, every split branch at its
    // boundaries, a fire after start and after a marker, and stop.
    drive_request(ldct_pkg::OP_TICK, 32'hFFFF_FFFF);
    drive_request(OP_UNUSED_LO, 32'hFFFF_FFFF);
    drive_request(OP_UNUSED_HI, '0);
    drive_request(ldct_pkg::OP_CAPTURE, '0);
    drive_request(ldct_pkg::OP_START, 32'd3);
    tick_run(4);
    drive_request(ldct_pkg::OP_START, PERIOD);
    drive_request(ldct_pkg::OP_START, PERIOD + 32'd1);
    drive_request(ldct_pkg::OP_START, TWO_PERIODS);
    drive_request(ldct_pkg::OP_START, TWO_PERIODS + 32'd1);
    drive_request(ldct_pkg::OP_START, 32'hFFFF_FFFF);
    drive_request(ldct_pkg::OP_START, '0);
    drive_request(ldct_pkg::OP_SET_DELAY, 32'd5);
    tick_run(2);
    drive_request(ldct_pkg::OP_CAPTURE, $urandom());
    drive_request(ldct_pkg::OP_SET_MARKED, 32'd2);
    tick_run(2);
    drive_request(ldct_pkg::OP_STOP, '0);
    drive_request(ldct_pkg::OP_TICK, '0);
    drive_request(ldct_pkg::OP_SET_DELAY, 32'hFFFF_FFFF);
    drive_request(ldct_pkg::OP_SET_MARKED, '0);

    // Random phases: free flow, slow sender, slow receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 79; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (phase == 0) pressure_go = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) run_burst();
    end

    // Drain: drop valid, stop stalling and wait out the pipeline.
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("tb_long_delay_compare_timer: PASS");
    end else begin
      $display("tb_long_delay_compare_timer: FAIL");
    end
    $finish;
  end

endmodule

FILE: long_delay_compare_timer.f
design/ldct_pkg.sv
design/ldct_split.sv
design/long_delay_compare_timer.sv
verif/tb_long_delay_compare_timer.sv
